>>> rtl/core/unique_value_deque_assert.svh
// Assertion macros for the unique value deque.
// UVD_ASSERT_IMP checks a consequence in the same cycle as its antecedent.
// UVD_ASSERT_NXT checks a consequence in the cycle after its antecedent.
`ifndef UNIQUE_VALUE_DEQUE_ASSERT_SVH
`define UNIQUE_VALUE_DEQUE_ASSERT_SVH
`ifndef SYNTHESIS
`define UVD_ASSERT_IMP(label, c, r, ante, cons) \
    label: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
        else $error("unique_value_deque: assertion failed");
`define UVD_ASSERT_NXT(label, c, r, ante, cons) \
    label: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
        else $error("unique_value_deque: assertion failed");
`else
`define UVD_ASSERT_IMP(label, c, r, ante, cons)
`define UVD_ASSERT_NXT(label, c, r, ante, cons)
`endif
`endif

>>> rtl/core/uvd_pkg.sv
package uvd_pkg;

    localparam int DEF_CAPACITY = 16;

    // Operation codes of a request word.
    localparam logic [2:0] OP_INS_FRONT = 3'd0;
    localparam logic [2:0] OP_INS_BACK  = 3'd1;
    localparam logic [2:0] OP_REM_FRONT = 3'd2;
    localparam logic [2:0] OP_REM_BACK  = 3'd3;
    localparam logic [2:0] OP_REM_VALUE = 3'd4;
    localparam logic [2:0] OP_LIST      = 3'd5;

    // Status codes of a response word.
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND  = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_LISTED    = 3'd6;

    // Write address selection.
    localparam logic [1:0] WR_FRONT = 2'd0;
    localparam logic [1:0] WR_BACK  = 2'd1;
    localparam logic [1:0] WR_SHIFT = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       clr_k;
        logic       inc_k;
        logic       rd_en;
        logic       rd_next;
        logic       wr_en;
        logic [1:0] wr_sel;
        logic       front_dec;
        logic       front_inc;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       out_load;
        logic       out_listed;
        logic [2:0] out_status;
    } uvd_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       count_zero;
        logic       is_full;
        logic       k_last;
        logic       match;
        logic       out_free;
    } uvd_stat_t;

endpackage

>>> rtl/core/uvd_req_if.sv
interface uvd_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic signed [31:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink (input valid, input operation, input value, output ready);
endinterface

>>> rtl/core/uvd_rsp_if.sv
interface uvd_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] entry_value;
    logic [4:0]         entry_count;
    logic               last;

    modport source (output valid, output status, output entry_value, output entry_count,
                    output last, input ready);
    modport sink (input valid, input status, input entry_value, input entry_count,
                  input last, output ready);
endinterface

>>> rtl/core/uvd_ctrl.sv
module uvd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  uvd_pkg::uvd_stat_t stat,
    output uvd_pkg::uvd_cmd_t  cmd
);
    import uvd_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_SCAN_RD  = 4'd2;
    localparam logic [3:0] S_SCAN_CMP = 4'd3;
    localparam logic [3:0] S_INSERT   = 4'd4;
    localparam logic [3:0] S_SHIFT    = 4'd5;
    localparam logic [3:0] S_SHIFT_WR = 4'd6;
    localparam logic [3:0] S_LIST_RD  = 4'd7;
    localparam logic [3:0] S_LIST_OUT = 4'd8;
    localparam logic [3:0] S_EMIT     = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [2:0] pend_reg;
    logic [2:0] pend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= ST_INSERTED;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        pend_next  = pend_reg;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    cmd.clr_k   = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.op)
                    OP_INS_FRONT, OP_INS_BACK:
                    begin
                        // An empty store has nothing to search and is never full.
                        state_next = stat.count_zero ? S_INSERT : S_SCAN_RD;
                    end
                    OP_REM_FRONT, OP_REM_BACK:
                    begin
                        if (stat.count_zero)
                        begin
                            pend_next = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.cnt_dec   = 1'b1;
                            cmd.front_inc = (stat.op == OP_REM_FRONT);
                            pend_next     = ST_REMOVED;
                        end
                        state_next = S_EMIT;
                    end
                    OP_REM_VALUE:
                    begin
                        if (stat.count_zero)
                        begin
                            pend_next  = ST_EMPTY;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    OP_LIST:
                    begin
                        if (stat.count_zero)
                        begin
                            pend_next  = ST_EMPTY;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_LIST_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (stat.match)
                begin
                    if (stat.op == OP_REM_VALUE)
                    begin
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        pend_next  = ST_DUPLICATE;
                        state_next = S_EMIT;
                    end
                end
                else if (stat.k_last)
                begin
                    if (stat.op == OP_REM_VALUE)
                    begin
                        pend_next  = ST_NOTFOUND;
                        state_next = S_EMIT;
                    end
                    else if (stat.is_full)
                    begin
                        pend_next  = ST_FULL;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_INSERT;
                    end
                end
                else
                begin
                    cmd.inc_k  = 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_INSERT:
            begin
                cmd.wr_en   = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.op == OP_INS_FRONT)
                begin
                    cmd.wr_sel    = WR_FRONT;
                    cmd.front_dec = 1'b1;
                end
                else
                begin
                    cmd.wr_sel = WR_BACK;
                end
                pend_next  = ST_INSERTED;
                state_next = S_EMIT;
            end
            S_SHIFT:
            begin
                // Close the gap: each later entry moves one place toward the front.
                if (stat.k_last)
                begin
                    cmd.cnt_dec = 1'b1;
                    pend_next   = ST_REMOVED;
                    state_next  = S_EMIT;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_next = 1'b1;
                    state_next  = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SHIFT;
                cmd.inc_k  = 1'b1;
                state_next = S_SHIFT;
            end
            S_LIST_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_LIST_OUT;
            end
            S_LIST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_listed = 1'b1;
                    cmd.out_status = ST_LISTED;
                    if (stat.k_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.inc_k  = 1'b1;
                        state_next = S_LIST_RD;
                    end
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = pend_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

>>> rtl/core/uvd_datapath.sv
module uvd_datapath #(
    parameter int CAPACITY = uvd_pkg::DEF_CAPACITY
) (
    input  logic               clk,
    input  logic               rst_n,
    input  uvd_pkg::uvd_cmd_t  cmd,
    output uvd_pkg::uvd_stat_t stat,
    input  logic [2:0]         req_operation,
    input  logic signed [31:0] req_value,
    input  logic               rsp_ready,
    output logic               rsp_valid,
    output logic [2:0]         rsp_status,
    output logic signed [31:0] rsp_entry_value,
    output logic [4:0]         rsp_entry_count,
    output logic               rsp_last
);
    import uvd_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SW = CW + 1;

    logic [2:0]         op_reg;
    logic signed [31:0] value_reg;
    logic [CW-1:0]      k_reg;
    logic [IW-1:0]      front_reg;
    logic [CW-1:0]      count_reg;
    logic signed [31:0] rdata_reg;
    logic signed [31:0] mem [CAPACITY];

    logic               out_valid_reg;
    logic [2:0]         out_status_reg;
    logic signed [31:0] out_value_reg;
    logic [4:0]         out_count_reg;
    logic               out_last_reg;

    logic [CW-1:0]      k_plus1;
    logic [CW-1:0]      rd_off;
    logic [IW-1:0]      rd_addr;
    logic [IW-1:0]      wr_addr;
    logic signed [31:0] wr_data;
    logic [IW-1:0]      front_m1;
    logic               k_last;

    // Slot of the entry at a given distance from the front, wrapping once.
    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] f, input logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(f) + SW'(off);
        if (s >= SW'(CAPACITY))
        begin
            s = s - SW'(CAPACITY);
        end
        return s[IW-1:0];
    endfunction

    assign k_plus1  = k_reg + 1'b1;
    assign k_last   = (k_plus1 == count_reg);
    assign rd_off   = cmd.rd_next ? k_plus1 : k_reg;
    assign rd_addr  = slot_of(front_reg, rd_off);
    assign front_m1 = (front_reg == '0) ? IW'(CAPACITY - 1) : front_reg - 1'b1;
    assign wr_data  = (cmd.wr_sel == WR_SHIFT) ? rdata_reg : value_reg;

    always_comb
    begin
        case (cmd.wr_sel)
            WR_FRONT: wr_addr = front_m1;
            WR_BACK:  wr_addr = slot_of(front_reg, count_reg);
            WR_SHIFT: wr_addr = slot_of(front_reg, k_reg);
            default:  wr_addr = slot_of(front_reg, k_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= req_operation;
            value_reg <= req_value;
        end
        if (cmd.clr_k)
        begin
            k_reg <= '0;
        end
        else if (cmd.inc_k)
        begin
            k_reg <= k_plus1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.front_dec)
            begin
                front_reg <= front_m1;
            end
            else if (cmd.front_inc)
            begin
                front_reg <= slot_of(front_reg, CW'(1));
            end
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_status;
            out_value_reg  <= cmd.out_listed ? rdata_reg : 32'sd0;
            out_count_reg  <= 5'(count_reg);
            out_last_reg   <= cmd.out_listed ? k_last : 1'b1;
        end
    end

    assign stat.op         = op_reg;
    assign stat.count_zero = (count_reg == '0);
    assign stat.is_full    = (count_reg >= CW'(CAPACITY));
    assign stat.k_last     = k_last;
    assign stat.match      = (rdata_reg == value_reg);
    assign stat.out_free   = !out_valid_reg || rsp_ready;

    assign rsp_valid       = out_valid_reg;
    assign rsp_status      = out_status_reg;
    assign rsp_entry_value = out_value_reg;
    assign rsp_entry_count = out_count_reg;
    assign rsp_last        = out_last_reg;
endmodule

>>> rtl/core/unique_value_deque.sv
// Ordered store of up to CAPACITY distinct signed 32-bit values, usable from both ends.
// The request channel carries one word per operation (operation code and value); the
// response channel returns status words, each with the stored count after the operation
// and a last flag marking the final word caused by that request.
// A request is taken only while the block is idle, so one operation runs at a time.
// Entries live in a single-port circular memory with a registered read, and every search,
// shift and listing step first reads an entry and then uses it.
// An insert searches the stored entries for a duplicate, remove front or back needs no
// search, and a value removal stops its search at the match, after which the shift only
// walks the entries behind it. A listing reads the entries out in order. Undefined
// operation codes are dropped without a response.
// Reset empties the store at once: front and count return to zero and the memory keeps
// whatever it held, since only entries that were written are ever read.
// A finished response waits in the output register; while the receiver stalls, the next
// request can still be taken, but an operation that needs to deliver pauses until the
// register frees, and a listing pauses between entries in the same way.
`include "unique_value_deque_assert.svh"

module unique_value_deque #(
    parameter int CAPACITY = uvd_pkg::DEF_CAPACITY
) (
    input logic        clk,
    input logic        rst_n,
    uvd_req_if.sink    req,
    uvd_rsp_if.source  rsp
);
    import uvd_pkg::*;

    uvd_cmd_t  cmd;
    uvd_stat_t stat;
    logic      ready;

    // The controller sequences each operation; the datapath owns the memory,
    // the front pointer, the count and the output register.
    uvd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    uvd_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .req_operation   (req.operation),
        .req_value       (req.value),
        .rsp_ready       (rsp.ready),
        .rsp_valid       (rsp.valid),
        .rsp_status      (rsp.status),
        .rsp_entry_value (rsp.entry_value),
        .rsp_entry_count (rsp.entry_count),
        .rsp_last        (rsp.last)
    );

    assign req.ready = ready;

    // Once a request is taken, no other is taken until it has been worked off.
    `UVD_ASSERT_NXT(a_one_at_a_time, clk, rst_n, req.valid && req.ready, !req.ready)
    // Words other than listed entries carry a zero value and end their request.
    `UVD_ASSERT_IMP(a_plain_word, clk, rst_n, rsp.valid && (rsp.status != ST_LISTED), (rsp.entry_value == 32'sd0) && rsp.last)
    // A listed entry was taken from a store that held something, so its count is not zero.
    `UVD_ASSERT_IMP(a_list_nonempty, clk, rst_n, rsp.valid && (rsp.status == ST_LISTED), rsp.entry_count != 5'd0)
    // The reported count never goes beyond the capacity.
    `UVD_ASSERT_IMP(a_count_bound, clk, rst_n, rsp.valid, 32'(rsp.entry_count) <= CAPACITY)
endmodule
